/* rtl/b2b_pkg.sv */
// shared constants, tables and control types of the blake2b hash engine
`timescale 1ns / 1ps

package b2b_pkg;

  localparam int unsigned WordW = 64;

  // initialization vector
  localparam logic [WordW-1:0] IV [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
    64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  // fanout 1, depth 1, no key
  localparam logic [WordW-1:0] PARAM_WORD = 64'h0000_0000_0101_0000;

  localparam logic [7:0] BLOCK_BYTES = 8'd128;
  localparam logic [3:0] LAST_ROUND = 4'd11;

  // message schedule, one row per round
  localparam logic [3:0] SIGMA [12][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}
  };

  // row rotation after a full mix step
  typedef enum logic [1:0] {
    ROT_COLUMN,
    ROT_TO_DIAG,
    ROT_FROM_DIAG
  } rot_mode_e;

  typedef struct packed {
    logic       accept;
    logic       pack;
    logic       add_full;
    logic       add_final;
    logic       init;
    logic       final_blk;
    logic       g_step;
    logic       half;
    rot_mode_e  rot_mode;
    logic [3:0] msg_idx;
    logic       fold;
    logic       restart;
    logic [2:0] out_idx;
  } b2b_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic buf_full;
    logic last;
    logic out_last;
  } b2b_status_t;

  // digest length as used: 0 counts as 1, above 64 as 64
  function automatic logic [6:0] used_len(input logic [6:0] len);
    logic [6:0] r;
    if (len == 7'd0) begin
      r = 7'd1;
    end else if (len > 7'd64) begin
      r = 7'd64;
    end else begin
      r = len;
    end
    return r;
  endfunction

  // low n bytes set, n up to 8
  function automatic logic [WordW-1:0] byte_mask(input logic [3:0] n);
    logic [WordW-1:0] r;
    if (n >= 4'd8) begin
      r = '1;
    end else begin
      r = (64'h1 << {n[2:0], 3'b000}) - 64'h1;
    end
    return r;
  endfunction

endpackage

/* rtl/b2b_datapath.sv */
// blake2b datapath: buffer packing, counter, work vector with one shared mix unit, digest
`timescale 1ns / 1ps

module b2b_datapath import b2b_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b2b_cmd_t          cmd_i,
  output b2b_status_t       status_o,
  input  logic [63:0]       message_word_i,
  input  logic [3:0]        valid_bytes_i,
  input  logic              message_end_i,
  input  logic              digest_length_we_i,
  input  logic [6:0]        digest_length_i,
  output logic [63:0]       digest_word_o,
  output logic [3:0]        digest_bytes_o,
  output logic              digest_last_o
);

  logic [6:0]   len_q;
  logic [63:0]  h_q [8];
  logic [63:0]  m_q [16];
  logic [63:0]  v_q [16];
  logic [7:0]   buf_q;
  logic [127:0] cnt_q;
  logic [63:0]  pend_q;
  logic [3:0]   rem_q;
  logic         last_q;

  logic [6:0]   ulen;
  logic [6:0]   cfg_ulen;
  logic         clean;

  assign ulen     = used_len(len_q);
  assign cfg_ulen = used_len(digest_length_i);
  assign clean    = (buf_q == 8'd0) && (cnt_q == 128'd0);

  // byte packing into the block buffer
  logic [2:0]  sh;
  logic [3:0]  widx;
  logic [7:0]  space;
  logic [3:0]  take;
  logic [63:0] data;
  logic [63:0] new_lo;
  logic [63:0] new_hi;
  logic        spill;
  logic [6:0]  hi_shift;

  always_comb begin
    sh       = buf_q[2:0];
    widx     = buf_q[6:3];
    space    = BLOCK_BYTES - buf_q;
    take     = ({4'b0, rem_q} < space) ? rem_q : space[3:0];
    data     = pend_q & byte_mask(take);
    new_lo   = (m_q[widx] & ((64'h1 << {sh, 3'b000}) - 64'h1)) | (data << {sh, 3'b000});
    hi_shift = 7'd64 - {1'b0, sh, 3'b000};
    new_hi   = data >> hi_shift;
    spill    = ({1'b0, sh} + take) > 4'd8;
  end

  // counter increment
  logic [7:0] cnt_add;
  assign cnt_add = cmd_i.add_full ? BLOCK_BYTES : buf_q;

  // half of the mix function on column zero
  logic [63:0] ga, gb, gc, gd, gm;
  logic [63:0] ga1, gb1, gc1, gd1, gx, gy;

  always_comb begin
    ga  = v_q[0];
    gb  = v_q[4];
    gc  = v_q[8];
    gd  = v_q[12];
    gm  = m_q[cmd_i.msg_idx];
    ga1 = ga + gb + gm;
    gx  = gd ^ ga1;
    gd1 = cmd_i.half ? {gx[15:0], gx[63:16]} : {gx[31:0], gx[63:32]};
    gc1 = gc + gd1;
    gy  = gb ^ gc1;
    gb1 = cmd_i.half ? {gy[62:0], gy[63]} : {gy[23:0], gy[63:24]};
  end

  // write back with per-row rotation after the second half
  logic [63:0] rowv [4][4];
  logic [63:0] v_next [16];
  logic [1:0]  amt;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        rowv[r][j] = v_q[4*r + j];
      end
    end
    rowv[0][0] = ga1;
    rowv[1][0] = gb1;
    rowv[2][0] = gc1;
    rowv[3][0] = gd1;
    for (int r = 0; r < 4; r++) begin
      unique case (cmd_i.rot_mode)
        ROT_TO_DIAG:   amt = 2'd1 + 2'(r);
        ROT_FROM_DIAG: amt = 2'd1 - 2'(r);
        default:       amt = 2'd1;
      endcase
      if (!cmd_i.half) begin
        amt = 2'd0;
      end
      for (int j = 0; j < 4; j++) begin
        v_next[4*r + j] = rowv[r][2'(j) + amt];
      end
    end
  end

  // chaining value, length register, counter and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 7'd64;
      buf_q <= 8'd0;
      cnt_q <= 128'd0;
      for (int i = 1; i < 8; i++) begin
        h_q[i] <= IV[i];
      end
      h_q[0] <= IV[0] ^ PARAM_WORD ^ 64'd64;
    end else begin
      if (digest_length_we_i && clean) begin
        len_q  <= digest_length_i;
        h_q[0] <= IV[0] ^ PARAM_WORD ^ {57'd0, cfg_ulen};
      end
      if (cmd_i.pack) begin
        buf_q <= buf_q + {4'd0, take};
      end
      if (cmd_i.add_full || cmd_i.add_final) begin
        cnt_q <= cnt_q + {120'd0, cnt_add};
      end
      if (cmd_i.add_full) begin
        buf_q <= 8'd0;
      end
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
        end
      end
      if (cmd_i.restart) begin
        buf_q <= 8'd0;
        cnt_q <= 128'd0;
        for (int i = 1; i < 8; i++) begin
          h_q[i] <= IV[i];
        end
        h_q[0] <= IV[0] ^ PARAM_WORD ^ {57'd0, ulen};
      end
    end
  end

  // input word, block buffer and work vector
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pend_q <= message_word_i;
      rem_q  <= (valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i;
      last_q <= message_end_i;
    end
    if (cmd_i.pack) begin
      pend_q     <= (take >= 4'd8) ? 64'd0 : (pend_q >> {take[2:0], 3'b000});
      rem_q      <= rem_q - take;
      m_q[widx]  <= new_lo;
      if (spill) begin
        m_q[widx + 4'd1] <= new_hi;
      end
    end
    if (cmd_i.add_final) begin
      for (int i = 0; i < 16; i++) begin
        if (8'(i * 8) >= buf_q) begin
          m_q[i] <= 64'd0;
        end
      end
    end
    if (cmd_i.init) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i]   <= h_q[i];
        v_q[i+8] <= IV[i];
      end
      v_q[12] <= IV[4] ^ cnt_q[63:0];
      v_q[13] <= IV[5] ^ cnt_q[127:64];
      v_q[14] <= cmd_i.final_blk ? ~IV[6] : IV[6];
    end
    if (cmd_i.g_step) begin
      for (int i = 0; i < 16; i++) begin
        v_q[i] <= v_next[i];
      end
    end
  end

  // digest output
  logic [6:0] obase;
  logic [6:0] orem;
  logic [3:0] nb;

  always_comb begin
    obase          = {1'b0, cmd_i.out_idx, 3'b000};
    orem           = ulen - obase;
    nb             = (orem >= 7'd8) ? 4'd8 : orem[3:0];
    digest_word_o  = h_q[cmd_i.out_idx] & byte_mask(nb);
    digest_bytes_o = nb;
    digest_last_o  = {1'b0, ulen} <= ({1'b0, obase} + 8'd8);
  end

  // status to controller
  assign status_o.rem_zero = (rem_q == 4'd0);
  assign status_o.buf_full = (buf_q == BLOCK_BYTES);
  assign status_o.last     = last_q;
  assign status_o.out_last = digest_last_o;

endmodule

/* rtl/b2b_ctrl.sv */
// blake2b controller: word intake, block compression sequencing, digest output
`timescale 1ns / 1ps

module b2b_ctrl import b2b_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  b2b_status_t status_i,
  output b2b_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PACK,
    S_INIT,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_e;

  state_e     state_q;
  logic [3:0] round_q;
  logic [2:0] step_q;
  logic       half_q;
  logic       fin_q;
  logic [2:0] idx_q;
  logic       out_valid_q;

  logic in_xfer;
  logic out_xfer;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_xfer     = in_valid_i && (state_q == S_IDLE);
  assign out_xfer    = out_valid_q && !out_stall_i;

  // commands to the datapath
  always_comb begin
    cmd_o           = '0;
    cmd_o.rot_mode  = ROT_COLUMN;
    cmd_o.accept    = in_xfer;
    cmd_o.final_blk = fin_q;
    cmd_o.half      = half_q;
    cmd_o.msg_idx   = SIGMA[round_q][{step_q, half_q}];
    cmd_o.out_idx   = idx_q;
    if (step_q == 3'd3) begin
      cmd_o.rot_mode = ROT_TO_DIAG;
    end else if (step_q == 3'd7) begin
      cmd_o.rot_mode = ROT_FROM_DIAG;
    end
    unique case (state_q)
      S_PACK: begin
        if (status_i.rem_zero) begin
          cmd_o.add_final = status_i.last;
        end else if (status_i.buf_full) begin
          cmd_o.add_full = 1'b1;
        end else begin
          cmd_o.pack = 1'b1;
        end
      end
      S_INIT:  cmd_o.init = 1'b1;
      S_ROUND: cmd_o.g_step = 1'b1;
      S_FOLD:  cmd_o.fold = 1'b1;
      S_OUT:   cmd_o.restart = out_xfer && status_i.out_last;
      default: ;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      round_q     <= 4'd0;
      step_q      <= 3'd0;
      half_q      <= 1'b0;
      fin_q       <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_PACK;
          end
        end
        S_PACK: begin
          if (status_i.rem_zero) begin
            if (status_i.last) begin
              fin_q   <= 1'b1;
              state_q <= S_INIT;
            end else begin
              state_q <= S_IDLE;
            end
          end else if (status_i.buf_full) begin
            fin_q   <= 1'b0;
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          round_q <= 4'd0;
          step_q  <= 3'd0;
          half_q  <= 1'b0;
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          half_q <= ~half_q;
          if (half_q) begin
            step_q <= step_q + 3'd1;
            if (step_q == 3'd7) begin
              if (round_q == LAST_ROUND) begin
                state_q <= S_FOLD;
              end else begin
                round_q <= round_q + 4'd1;
              end
            end
          end
        end
        S_FOLD: begin
          if (fin_q) begin
            idx_q       <= 3'd0;
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            state_q <= S_PACK;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            if (status_i.out_last) begin
              out_valid_q <= 1'b0;
              fin_q       <= 1'b0;
              state_q     <= S_IDLE;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/blake2b_hash.sv */
// blake2b hash engine top level
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_stall_o    message_word_i, valid_bytes_i,
//                                                   message_end_i
//   output    out        out_valid_o / out_stall_i  digest_word_o, digest_bytes_o,
//                                                   digest_last_o
//   config    in         digest_length_we_i         digest_length_i
//
// A word is accepted and then packed into the block buffer one piece at a time; a full
// 128-byte block then adds a compression (12 rounds of 16 half mix steps on the shared
// mix unit). The final word adds one compression and then the digest word transfers.
// Input stalls while a word or block is in work or while the digest drains. Reset
// restores the 64-byte length and the initial chain value.
`timescale 1ns / 1ps

module blake2b_hash import b2b_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        message_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_word_o,
  output logic [3:0]  digest_bytes_o,
  output logic        digest_last_o,
  input  logic        digest_length_we_i,
  input  logic [6:0]  digest_length_i
);

  b2b_cmd_t    cmd;
  b2b_status_t status;

  // sequencing
  b2b_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // hashing datapath
  b2b_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .message_word_i     (message_word_i),
    .valid_bytes_i      (valid_bytes_i),
    .message_end_i      (message_end_i),
    .digest_length_we_i (digest_length_we_i),
    .digest_length_i    (digest_length_i),
    .digest_word_o      (digest_word_o),
    .digest_bytes_o     (digest_bytes_o),
    .digest_last_o      (digest_last_o)
  );

endmodule

/* test/tb_blake2b_hash.sv */
// self-checking testbench of the blake2b hash engine
`timescale 1ns / 1ps

module tb_blake2b_hash;
  import b2b_pkg::*;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic        cfg;
    logic [6:0]  len;
  } msg_item_t;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } digest_item_t;

  localparam logic [63:0] IV_TAB [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
    64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };
  localparam int SCHED [12][16] = '{
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
    '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
    '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
    '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
    '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
    '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
    '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
    '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
    '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
    '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0},
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
    '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3}
  };
  localparam longint CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [63:0] message_word_i = '0;
  logic [3:0] valid_bytes_i = '0;
  logic message_end_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [63:0] digest_word_o;
  logic [3:0] digest_bytes_o;
  logic digest_last_o;
  logic digest_length_we_i = 1'b0;
  logic [6:0] digest_length_i = '0;

  blake2b_hash dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .message_word_i, .valid_bytes_i,
    .message_end_i, .out_valid_o, .out_stall_i, .digest_word_o, .digest_bytes_o,
    .digest_last_o, .digest_length_we_i, .digest_length_i
  );

  // predictor state
  logic [6:0]  len_reg;
  logic [63:0] hstate [8];
  logic [63:0] mbuf [16];
  int unsigned nbuf;
  logic [127:0] count;
  logic [63:0] wv [16];

  msg_item_t    pending_q [$];
  digest_item_t digest_q [$];
  int  send_idle_pct, recv_idle_pct, hold_left;
  int  errors, words_sent, digests_seen;
  longint cycles;

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [6:0] eff_len();
    if (len_reg == 7'd0) return 7'd1;
    if (len_reg > 7'd64) return 7'd64;
    return len_reg;
  endfunction

  function automatic void start_msg();
    for (int i = 0; i < 8; i++) hstate[i] = IV_TAB[i];
    hstate[0] ^= 64'h01010000 ^ 64'(eff_len());
    for (int i = 0; i < 16; i++) mbuf[i] = '0;
    nbuf = 0;
    count = '0;
  endfunction

  function automatic void g_mix(int r, int k, int a, int b, int c, int d);
    wv[a] = wv[a] + wv[b] + mbuf[SCHED[r][2*k]];
    wv[d] = {wv[d] ^ wv[a]} >> 32 | {wv[d] ^ wv[a]} << 32;
    wv[c] = wv[c] + wv[d];
    wv[b] = {wv[b] ^ wv[c]} >> 24 | {wv[b] ^ wv[c]} << 40;
    wv[a] = wv[a] + wv[b] + mbuf[SCHED[r][2*k+1]];
    wv[d] = {wv[d] ^ wv[a]} >> 16 | {wv[d] ^ wv[a]} << 48;
    wv[c] = wv[c] + wv[d];
    wv[b] = {wv[b] ^ wv[c]} >> 63 | {wv[b] ^ wv[c]} << 1;
  endfunction

  function automatic void compress_block(bit fin);
    for (int i = 0; i < 8; i++) begin
      wv[i] = hstate[i];
      wv[i+8] = IV_TAB[i];
    end
    wv[12] ^= count[63:0];
    wv[13] ^= count[127:64];
    if (fin) wv[14] = ~wv[14];
    for (int r = 0; r < 12; r++) begin
      g_mix(r, 0, 0, 4, 8, 12);
      g_mix(r, 1, 1, 5, 9, 13);
      g_mix(r, 2, 2, 6, 10, 14);
      g_mix(r, 3, 3, 7, 11, 15);
      g_mix(r, 4, 0, 5, 10, 15);
      g_mix(r, 5, 1, 6, 11, 12);
      g_mix(r, 6, 2, 7, 8, 13);
      g_mix(r, 7, 3, 4, 9, 14);
    end
    for (int i = 0; i < 8; i++) hstate[i] ^= wv[i] ^ wv[i+8];
  endfunction

  // absorb one word and queue the digest words it yields
  function automatic void hash_word(logic [63:0] w, logic [3:0] nb, logic fin);
    int unsigned n, len, nw, rem;
    digest_item_t d;
    n = (nb > 4'd8) ? 8 : nb;
    for (int i = 0; i < n; i++) begin
      if (nbuf >= 128) begin
        count += 128;
        compress_block(1'b0);
        nbuf = 0;
      end
      if (nbuf % 8 == 0) mbuf[nbuf/8] = '0;
      mbuf[nbuf/8] |= 64'(w[8*i +: 8]) << (8 * (nbuf % 8));
      nbuf++;
    end
    if (!fin) return;
    count += nbuf;
    if (nbuf < 128) begin
      for (int i = 0; i < 16; i++) begin
        if (i * 8 >= nbuf) mbuf[i] = '0;
        else if (i * 8 + 8 > nbuf) mbuf[i] &= (64'h1 << (8 * (nbuf % 8))) - 1;
      end
    end
    compress_block(1'b1);
    len = eff_len();
    nw = (len + 7) / 8;
    for (int i = 0; i < nw; i++) begin
      rem = len - 8 * i;
      d.nbytes = (rem >= 8) ? 4'd8 : 4'(rem);
      d.word = hstate[i];
      if (rem < 8) d.word &= (64'h1 << (8 * rem)) - 1;
      d.last = (i + 1 == nw);
      digest_q.push_back(d);
    end
    start_msg();
  endfunction

  function automatic void add_word(logic [63:0] w, logic [3:0] nb, logic fin);
    msg_item_t m;
    m.word = w; m.nbytes = nb; m.last = fin; m.cfg = 1'b0; m.len = '0;
    pending_q.push_back(m);
  endfunction

  function automatic void add_cfg(logic [6:0] len);
    msg_item_t m;
    m.word = '0; m.nbytes = '0; m.last = 1'b0; m.cfg = 1'b1; m.len = len;
    pending_q.push_back(m);
  endfunction

  // random message, mostly short, sometimes past one block
  function automatic void add_message(int max_words);
    int nw;
    nw = $urandom_range(0, max_words);
    for (int i = 0; i < nw; i++) begin
      add_word({$urandom, $urandom},
               ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8, 1'b0);
    end
    add_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
  endfunction

  // driver: word transfers, and config writes once the engine has drained
  always @(posedge clk_i) begin
    bit cfg_wr;
    cfg_wr = 1'b0;
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) begin
          hash_word(message_word_i, valid_bytes_i, message_end_i);
          words_sent++;
        end
        if (pending_q.size() > 0 && pending_q[0].cfg) begin
          in_valid_i <= 1'b0;
          if (!in_valid_i && digest_q.size() == 0) begin
            digest_length_i <= pending_q[0].len;
            cfg_wr = 1'b1;
            len_reg = pending_q[0].len;
            start_msg();
            void'(pending_q.pop_front());
          end
        end else if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          message_word_i <= pending_q[0].word;
          valid_bytes_i <= pending_q[0].nbytes;
          message_end_i <= pending_q[0].last;
          void'(pending_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
    digest_length_we_i <= cfg_wr;
  end

  // receiver stall, with a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor: compare each digest transfer with the oldest expectation
  always @(posedge clk_i) begin
    digest_item_t e;
    cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h", $realtime, digest_word_o);
        errors++;
      end else begin
        e = digest_q.pop_front();
        if (digest_word_o !== e.word) begin
          $display("%0t: digest_word expected %h actual %h", $realtime, e.word, digest_word_o);
          errors++;
        end
        if (digest_bytes_o !== e.nbytes) begin
          $display("%0t: digest_bytes expected %0d actual %0d", $realtime, e.nbytes,
                   digest_bytes_o);
          errors++;
        end
        if (digest_last_o !== e.last) begin
          $display("%0t: digest_last expected %0d actual %0d", $realtime, e.last,
                   digest_last_o);
          errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    errors = 0; words_sent = 0; digests_seen = 0; cycles = 0; hold_left = 0;
    send_idle_pct = 37; recv_idle_pct = 58;
    len_reg = 7'd64;
    start_msg();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty message, extremes, short words, one full block, odd lengths
    add_word('0, 4'd0, 1'b1);
    add_word('1, 4'd8, 1'b1);
    add_word(64'h0123456789ABCDEF, 4'd3, 1'b0);
    add_word(64'hFEDCBA9876543210, 4'd15, 1'b1);
    for (int i = 0; i < 16; i++) add_word({$urandom, $urandom}, 4'd8, 1'b0);
    add_word('0, 4'd0, 1'b1);
    add_cfg(7'd1);
    add_word(64'h00000000000000FF, 4'd1, 1'b1);
    add_cfg(7'd0);
    add_word('1, 4'd8, 1'b1);
    add_cfg(7'd127);
    add_word(64'h5555AAAA5555AAAA, 4'd9, 1'b1);
    add_cfg(7'd33);
    add_message(20);

    // random: several settings across the three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      for (int m = 0; m < 15; m++) begin
        if (m % 4 == 0) add_cfg(($urandom_range(0, 4) == 0) ? 7'($urandom) :
                                7'($urandom_range(1, 64)));
        add_message(($urandom_range(0, 5) == 0) ? 40 : 10);
      end
      if (ph == 1) hold_left = 600;
      while (pending_q.size() > 0 || in_valid_i || digest_q.size() > 0)
        @(posedge clk_i);
      repeat (250) @(posedge clk_i);
      if (ph == 0) begin send_idle_pct = 58; recv_idle_pct = 37; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
    end
    add_cfg(7'd64);
    repeat (2) @(posedge clk_i);

    $display("sent %0d message words, checked %0d digest words over several lengths",
             words_sent, digests_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
